// ----- rtl/vfie_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vfie_pkg
// Shared types and constants of the variable file instruction executor.
// ============================================================================
package vfie_pkg;

    localparam int VAR_COUNT_DEF     = 1024;
    localparam int PROGRAM_DEPTH_DEF = 4096;
    localparam int WORD_WIDTH_DEF    = 32;

    localparam int REQ_W    = 2;
    localparam int OP_W     = 5;
    localparam int IDX_W    = 10;
    localparam int TGT_W    = 12;
    localparam int VAL_W    = 32;
    localparam int KIND_W   = 3;

    localparam logic [REQ_W-1:0] REQ_EXEC  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RSVD  = 2'd3;

    localparam logic [OP_W-1:0] OP_COPY  = 5'd0;
    localparam logic [OP_W-1:0] OP_CEQ   = 5'd1;
    localparam logic [OP_W-1:0] OP_CGT   = 5'd6;
    localparam logic [OP_W-1:0] OP_ADD   = 5'd7;
    localparam logic [OP_W-1:0] OP_SUB   = 5'd8;
    localparam logic [OP_W-1:0] OP_MUL   = 5'd9;
    localparam logic [OP_W-1:0] OP_DIV   = 5'd10;
    localparam logic [OP_W-1:0] OP_MOD   = 5'd11;
    localparam logic [OP_W-1:0] OP_AND   = 5'd12;
    localparam logic [OP_W-1:0] OP_SHR   = 5'd13;
    localparam logic [OP_W-1:0] OP_INC   = 5'd14;
    localparam logic [OP_W-1:0] OP_NEG   = 5'd15;
    localparam logic [OP_W-1:0] OP_GOTO  = 5'd16;
    localparam logic [OP_W-1:0] OP_JEQ   = 5'd17;
    localparam logic [OP_W-1:0] OP_JGT   = 5'd22;
    localparam logic [OP_W-1:0] OP_LOOP  = 5'd23;
    localparam logic [OP_W-1:0] OP_PRINT = 5'd24;
    localparam logic [OP_W-1:0] OP_TIME  = 5'd25;
    localparam logic [OP_W-1:0] OP_END   = 5'd26;
    localparam logic [OP_W-1:0] OP_RSVD  = 5'd31;

    localparam logic [KIND_W-1:0] K_NEXT  = 3'd0;
    localparam logic [KIND_W-1:0] K_JUMP  = 3'd1;
    localparam logic [KIND_W-1:0] K_PRINT = 3'd2;
    localparam logic [KIND_W-1:0] K_TIME  = 3'd3;
    localparam logic [KIND_W-1:0] K_END   = 3'd4;
    localparam logic [KIND_W-1:0] K_READ  = 3'd5;
    localparam logic [KIND_W-1:0] K_DIVZ  = 3'd6;

    // Compare selectors, shared by set-on-compare and conditional jumps.
    localparam logic [2:0] CMP_EQ = 3'd0;
    localparam logic [2:0] CMP_NE = 3'd1;
    localparam logic [2:0] CMP_LE = 3'd2;
    localparam logic [2:0] CMP_GE = 3'd3;
    localparam logic [2:0] CMP_LT = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [OP_W-1:0]  opcode;
        logic [IDX_W-1:0] dest_index;
        logic [IDX_W-1:0] src_a_index;
        logic [IDX_W-1:0] src_b_index;
        logic [TGT_W-1:0] jump_target;
        logic signed [VAL_W-1:0] write_value;
    } t_req;

    typedef struct packed {
        logic [KIND_W-1:0]       result_kind;
        logic signed [VAL_W-1:0] result_value;
        logic [TGT_W-1:0]        next_target;
    } t_rsp;

endpackage

// ----- rtl/vfie_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vfie_req_if / vfie_rsp_if
// Valid/ready channels for requests and results.
// ============================================================================
interface vfie_req_if;
    logic           valid;
    logic           ready;
    vfie_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface vfie_rsp_if;
    logic           valid;
    logic           ready;
    vfie_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/variable_file_instruction_executor.sv -----
`timescale 1ns / 1ps
// ============================================================================
// variable_file_instruction_executor
// Memory-to-memory bytecode executor over a cleared file of signed variables.
// ============================================================================
//  Channel  Dir  Payload
//  i_req    in   req_type, opcode, indices, jump_target, write_value
//  o_rsp    out  result_kind, result_value, next_target
//
//  After reset a clearing pass zeroes VAR_COUNT entries, one per cycle,
//  while no request is taken. The result is valid once the item has passed
//  S_RDD (read the destination), S_EXEC (execute) and S_WB (write back);
//  divide and modulo by a divisor other than 0 or -1 also wait in S_DIV
//  for the divider. One item is in flight: the next request is taken no
//  earlier than the cycle after the result transfer.
// ============================================================================
module variable_file_instruction_executor #(
    parameter int VAR_COUNT     = vfie_pkg::VAR_COUNT_DEF,
    parameter int PROGRAM_DEPTH = vfie_pkg::PROGRAM_DEPTH_DEF,
    parameter int WORD_WIDTH    = vfie_pkg::WORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vfie_req_if.sink    i_req,
    vfie_rsp_if.source  o_rsp
);
    localparam int AW  = $clog2(VAR_COUNT);
    localparam int PW  = $clog2(PROGRAM_DEPTH);
    localparam int SHW = $clog2(WORD_WIDTH);
    localparam int VW  = vfie_pkg::VAL_W;
    localparam int TW  = vfie_pkg::TGT_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RDD, S_EXEC, S_DIV, S_WB
    } t_state;

    t_state r_state;
    logic [WORD_WIDTH-1:0] r_mem [VAR_COUNT];
    logic [AW:0]           r_clr;
    vfie_pkg::t_req        r_req;
    logic [WORD_WIDTH-1:0] r_rd0, r_rd1, r_a, r_b, r_res;
    logic                  r_we;
    logic [AW-1:0]         r_ra0, r_ra1;
    vfie_pkg::t_rsp        r_out;
    logic                  r_ov;

    logic [AW-1:0]         n_da, n_ba;
    logic [AW-1:0]         n_rda0, n_rda1;
    logic                  n_div_start, div_done;
    logic [WORD_WIDTH-1:0] div_q, div_r;

    logic signed [WORD_WIDTH-1:0] sa, sb, sc;
    logic [WORD_WIDTH-1:0] n_val, n_inc;
    logic [SHW-1:0]        n_sh;
    logic                  n_we, n_jump;
    logic [2:0]            n_sel;
    logic [vfie_pkg::KIND_W-1:0] n_kind;
    logic [VW-1:0]         n_rv;

    function automatic logic cmp(input logic [2:0] sel,
                                 input logic signed [WORD_WIDTH-1:0] a,
                                 input logic signed [WORD_WIDTH-1:0] b);
        logic res;
        case (sel)
            vfie_pkg::CMP_EQ: res = (a == b);
            vfie_pkg::CMP_NE: res = (a != b);
            vfie_pkg::CMP_LE: res = (a <= b);
            vfie_pkg::CMP_GE: res = (a >= b);
            vfie_pkg::CMP_LT: res = (a < b);
            default:          res = (a > b);
        endcase
        return res;
    endfunction

    function automatic logic [VW-1:0] to_val(input logic [WORD_WIDTH-1:0] w);
        logic [63:0] x;
        x = 64'(signed'(w));
        return x[VW-1:0];
    endfunction

    assign n_da = AW'(r_req.dest_index % VAR_COUNT);
    assign n_ba = AW'(r_req.src_b_index % VAR_COUNT);

    // Sources are read at the request transfer so they are ready in S_RDD.
    assign n_rda0 = (r_state == S_IDLE) ? AW'(i_req.payload.src_a_index % VAR_COUNT)
                                        : r_ra0;
    assign n_rda1 = (r_state == S_IDLE) ? AW'(i_req.payload.src_b_index % VAR_COUNT)
                                        : r_ra1;

    assign i_req.ready = (r_state == S_IDLE) && !r_ov;
    assign o_rsp.valid = r_ov;
    assign o_rsp.payload = r_out;

    vfie_div #(.WORD_WIDTH(WORD_WIDTH)) u_div (
        .i_clk, .i_rst_n,
        .i_start(n_div_start), .i_dividend(r_a), .i_divisor(r_b),
        .o_done(div_done), .o_quot(div_q), .o_rem(div_r)
    );

    // Execute stage: r_a, r_b hold the sources, r_rd0 the destination word.
    always_comb begin
        sa = signed'(r_a);
        sb = signed'(r_b);
        n_inc = r_rd0 + 1'b1;
        sc = signed'(n_inc);
        if (sb < 0) n_sh = '0;
        else if (sb > WORD_WIDTH - 1) n_sh = SHW'(WORD_WIDTH - 1);
        else n_sh = r_b[SHW-1:0];
        n_val = '0; n_we = 1'b0; n_jump = 1'b0;
        n_kind = vfie_pkg::K_NEXT; n_rv = '0;
        n_sel = 3'(r_req.opcode - vfie_pkg::OP_CEQ);
        n_div_start = 1'b0;
        case (r_req.req_type)
            vfie_pkg::REQ_WRITE: begin
                n_we = 1'b1;
                n_val = WORD_WIDTH'(r_req.write_value);
            end
            vfie_pkg::REQ_READ: begin
                n_kind = vfie_pkg::K_READ;
                n_rv = to_val(r_rd0);
            end
            vfie_pkg::REQ_EXEC: begin
                case (r_req.opcode) inside
                    vfie_pkg::OP_COPY: begin n_we = 1'b1; n_val = r_a; end
                    [vfie_pkg::OP_CEQ:vfie_pkg::OP_CGT]: begin
                        n_we = 1'b1;
                        n_val = WORD_WIDTH'(cmp(n_sel, sa, sb));
                    end
                    vfie_pkg::OP_ADD: begin n_we = 1'b1; n_val = r_a + r_b; end
                    vfie_pkg::OP_SUB: begin n_we = 1'b1; n_val = r_a - r_b; end
                    vfie_pkg::OP_MUL: begin n_we = 1'b1; n_val = r_res; end
                    vfie_pkg::OP_DIV, vfie_pkg::OP_MOD: begin
                        n_we = 1'b1;
                        if (r_b == '0) n_kind = vfie_pkg::K_DIVZ;
                        else if (r_b == '1)
                            n_val = (r_req.opcode == vfie_pkg::OP_DIV) ? -r_a : '0;
                        else begin
                            n_div_start = (r_state == S_EXEC);
                            n_val = (r_req.opcode == vfie_pkg::OP_DIV) ? div_q : div_r;
                        end
                    end
                    vfie_pkg::OP_AND: begin n_we = 1'b1; n_val = r_a & r_b; end
                    vfie_pkg::OP_SHR: begin n_we = 1'b1; n_val = WORD_WIDTH'(sa >>> n_sh); end
                    vfie_pkg::OP_INC: begin n_we = 1'b1; n_val = n_inc; end
                    vfie_pkg::OP_NEG: begin n_we = 1'b1; n_val = -r_a; end
                    vfie_pkg::OP_GOTO: n_jump = 1'b1;
                    [vfie_pkg::OP_JEQ:vfie_pkg::OP_JGT]: begin
                        n_sel = 3'(r_req.opcode - vfie_pkg::OP_JEQ);
                        n_jump = cmp(n_sel, sa, sb);
                    end
                    vfie_pkg::OP_LOOP: begin
                        n_we = 1'b1; n_val = n_inc;
                        // Limit read after the counter write: same entry never jumps.
                        n_jump = (n_ba != n_da) && (sc < sb);
                    end
                    vfie_pkg::OP_PRINT: begin n_kind = vfie_pkg::K_PRINT; n_rv = to_val(r_rd0); end
                    vfie_pkg::OP_TIME: n_kind = vfie_pkg::K_TIME;
                    vfie_pkg::OP_END:  n_kind = vfie_pkg::K_END;
                    default: ;
                endcase
                if (n_jump) n_kind = vfie_pkg::K_JUMP;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_we    <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) r_ov <= 1'b0;
            r_we <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(VAR_COUNT - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req <= i_req.payload;
                        r_ra0 <= AW'(i_req.payload.src_a_index % VAR_COUNT);
                        r_ra1 <= AW'(i_req.payload.src_b_index % VAR_COUNT);
                        r_state <= S_RDD;
                    end
                end
                S_RDD: begin
                    r_a <= r_rd0; r_b <= r_rd1;
                    r_ra0 <= n_da;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_res <= r_a * r_b;
                    r_state <= n_div_start ? S_DIV : S_WB;
                end
                S_DIV: if (div_done) r_state <= S_WB;
                S_WB: begin
                    r_we  <= n_we;
                    r_res <= n_val;
                    r_ra0 <= n_da;
                    r_out.result_kind  <= n_kind;
                    r_out.result_value <= signed'(n_rv);
                    r_out.next_target  <= n_jump ? TW'(PW'(r_req.jump_target % PROGRAM_DEPTH)) : '0;
                    r_ov    <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // Variable file: two registered reads, one write.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) r_mem[r_clr[AW-1:0]] <= '0;
        else if (r_we) r_mem[r_ra0] <= r_res;
        r_rd0 <= r_mem[n_rda0];
        r_rd1 <= r_mem[n_rda1];
    end

    property p_one_item;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_req.valid && i_req.ready) |=> (r_state == S_RDD);
    endproperty
    a_one_item: assert property (p_one_item) else $error("request taken outside idle");

    property p_no_ready_clear;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_CLEAR) |-> !i_req.ready;
    endproperty
    a_no_ready_clear: assert property (p_no_ready_clear) else $error("ready during clear");

    property p_jump_target;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_rsp.valid && o_rsp.payload.result_kind != vfie_pkg::K_JUMP)
                |-> (o_rsp.payload.next_target == '0);
    endproperty
    a_jump_target: assert property (p_jump_target) else $error("target without jump");
endmodule

// ----- rtl/vfie_div.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vfie_div
// Iterative signed divider, one quotient bit per cycle, C truncation rules.
// ============================================================================
module vfie_div #(
    parameter int WORD_WIDTH = vfie_pkg::WORD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WORD_WIDTH-1:0] i_dividend,
    input  logic [WORD_WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [WORD_WIDTH-1:0] o_quot,
    output logic [WORD_WIDTH-1:0] o_rem
);
    localparam int CNT_W = $clog2(WORD_WIDTH + 1);

    logic [WORD_WIDTH-1:0] r_num, r_den, r_quot, r_rem;
    logic                  r_neg_q, r_neg_r, r_busy, r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [WORD_WIDTH:0]   n_part;
    logic [WORD_WIDTH:0]   n_diff;

    always_comb begin
        n_part = {r_rem, r_num[WORD_WIDTH-1]};
        n_diff = n_part - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= CNT_W'(WORD_WIDTH);
                r_num   <= i_dividend[WORD_WIDTH-1] ? -i_dividend : i_dividend;
                r_den   <= i_divisor[WORD_WIDTH-1] ? -i_divisor : i_divisor;
                r_neg_q <= i_dividend[WORD_WIDTH-1] ^ i_divisor[WORD_WIDTH-1];
                r_neg_r <= i_dividend[WORD_WIDTH-1];
                r_rem   <= '0;
                r_quot  <= '0;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (!n_diff[WORD_WIDTH]) begin
                    r_rem  <= n_diff[WORD_WIDTH-1:0];
                    r_quot <= {r_quot[WORD_WIDTH-2:0], 1'b1};
                end else begin
                    r_rem  <= n_part[WORD_WIDTH-1:0];
                    r_quot <= {r_quot[WORD_WIDTH-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg_q ? -r_quot : r_quot;
    assign o_rem  = r_neg_r ? -r_rem : r_rem;
endmodule
